@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/dav_pkg.sv @@
// ----------------------------------------------------------------------------
// dav_pkg
// Shared types, constants and tables of the decaying additive voice bank.
// ----------------------------------------------------------------------------
package dav_pkg;

    localparam int VOICES      = 9;
    localparam int VOICE_W     = 4;
    localparam int PHASE_W     = 36;
    localparam int STEP_W      = 32;
    localparam int AMP_W       = 24;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_AW     = 10;
    localparam int PARTIALS    = 6;
    localparam int PART_W      = 3;

    localparam logic [AMP_W-1:0] PEAK_RESET  = 24'd15099494;
    localparam logic [AMP_W-1:0] DECAY_RESET = 24'd16776682;

    localparam logic [2:0] ADDR_PEAK  = 3'd0;
    localparam logic [2:0] ADDR_DECAY = 3'd4;

    // Taylor series divisors (2k)(2k+1) for k = 1..7.
    localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156, 64'd210};

    // One queued input beat.
    typedef struct packed {
        logic              pick;
        logic [STEP_W-1:0] step;
    } dav_item_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic      valid;
        dav_item_t item;
    } dav_head_t;

    typedef struct packed {
        logic [AMP_W-1:0] peak;
        logic [AMP_W-1:0] decay;
    } dav_cfg_t;

    typedef logic [15:0] sine_rom_t [SINE_DEPTH];

    // Q1.15 partial weights.
    function automatic logic signed [16:0] partial_weight(input logic [PART_W-1:0] k);
        logic signed [16:0] w;
        case (k)
            3'd0:    w = 17'sd32768;
            3'd1:    w = 17'sd2731;
            3'd2:    w = -17'sd19115;
            3'd3:    w = 17'sd1365;
            3'd4:    w = -17'sd17749;
            3'd5:    w = -17'sd11605;
            default: w = 17'sd0;
        endcase
        return w;
    endfunction

    // Partial phase as a 32-bit turn fraction: x1, x2, x1/2, x8, x1/4, x1/16.
    function automatic logic [31:0] partial_turn(input logic [PHASE_W-1:0] p,
                                                 input logic [PART_W-1:0] k);
        logic [31:0] u;
        case (k)
            3'd0:    u = p[31:0];
            3'd1:    u = {p[30:0], 1'b0};
            3'd2:    u = p[32:1];
            3'd3:    u = {p[28:0], 3'b000};
            3'd4:    u = p[33:2];
            3'd5:    u = p[35:4];
            default: u = 32'd0;
        endcase
        return u;
    endfunction

    // Quarter-wave table, Taylor series in Q30 to the x^15 term.
    function automatic sine_rom_t build_sine();
        sine_rom_t          t;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint unsigned    v;
        longint             s;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x    = (longint'(i) * 64'd1686629713) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k % 2 == 1) s = s - longint'(term);
                else            s = s + longint'(term);
            end
            if (s < 0) s = 0;
            if (s > (longint'(1) << 30)) s = longint'(1) << 30;
            v = (longint'(s) * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767) v = 32767;
            t[i] = v[15:0];
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

endpackage

@@ rtl/dav_cfg.sv @@
// ----------------------------------------------------------------------------
// dav_cfg
// APB register file: peak amplitude and decay factor.
// ----------------------------------------------------------------------------
module dav_cfg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output dav_pkg::dav_cfg_t cfg
);
    import dav_pkg::*;

    logic [AMP_W-1:0] peak_reg;
    logic [AMP_W-1:0] decay_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= PEAK_RESET;
            decay_reg <= DECAY_RESET;
        end else if (wr_en) begin
            if (paddr == ADDR_PEAK)  peak_reg  <= pwdata[AMP_W-1:0];
            if (paddr == ADDR_DECAY) decay_reg <= pwdata[AMP_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_PEAK:  prdata = {8'd0, peak_reg};
            ADDR_DECAY: prdata = {8'd0, decay_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.peak  = peak_reg;
    assign cfg.decay = decay_reg;

endmodule

@@ rtl/dav_front.sv @@
// ----------------------------------------------------------------------------
// dav_front
// Input side: accepts beats, tags picks and ticks, two-entry queue.
// ----------------------------------------------------------------------------
module dav_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    output dav_pkg::dav_head_t head,
    input  logic              pop
);
    import dav_pkg::*;

    dav_item_t  q_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       do_pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid & s_tready;
    assign do_pop   = pop & (cnt_reg != 2'd0);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg].pick <= s_tuser[0];
            q_reg[wptr_reg].step <= s_tdata;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push)   wptr_reg <= ~wptr_reg;
            if (do_pop) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rptr_reg];

endmodule

@@ rtl/dav_back.sv @@
// ----------------------------------------------------------------------------
// dav_back
// Voice engine: picks update one voice; ticks run all partials through one
// sine ROM port and one MAC, then mix, scale and saturate.
// ----------------------------------------------------------------------------
module dav_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dav_pkg::dav_head_t head,
    output logic               pop,
    input  dav_pkg::dav_cfg_t  cfg,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata
);
    import dav_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PART  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_VMUL  = 3'd3;
    localparam logic [2:0] ST_VACC  = 3'd4;
    localparam logic [2:0] ST_FIN1  = 3'd5;
    localparam logic [2:0] ST_FIN2  = 3'd6;
    localparam logic [2:0] ST_FIN3  = 3'd7;

    localparam logic [20:0] SAT_LIM = 21'd294912;   // 9 * 32768
    localparam logic [20:0] RECIP9  = 21'd1864136;  // ceil(2^24 / 9)

    logic [PHASE_W-1:0] phase_reg [VOICES];
    logic [STEP_W-1:0]  step_reg  [VOICES];
    logic [AMP_W-1:0]   amp_reg   [VOICES];
    logic [VOICE_W-1:0] next_voice_reg;

    logic [2:0]          state_reg;
    logic [VOICE_W-1:0]  vidx_reg;
    logic [PART_W-1:0]   kidx_reg;
    logic                mac_vld_reg;
    logic [PART_W-1:0]   mac_k_reg;
    logic                mac_neg_reg;
    logic [15:0]         rom_q_reg;
    logic signed [33:0]  sum_reg;
    logic signed [57:0]  prod_reg;
    logic signed [36:0]  total_reg;
    logic [50:0]         mag_reg;
    logic                neg_reg;
    logic [14:0]         nq_reg;
    logic                sat_reg;
    logic                out_vld_reg;
    logic [15:0]         out_reg;

    logic [31:0]         turn;
    logic [29:0]         rfold;
    logic [SINE_AW-1:0]  rom_idx;
    logic signed [16:0]  sine_s;
    logic signed [33:0]  mac_prod;
    logic signed [57:0]  prod_bias;
    logic signed [33:0]  vval;
    logic [47:0]         dec_prod;
    logic [VOICE_W-1:0]  pick_v;
    logic [VOICE_W-1:0]  pick_nxt;
    logic signed [36:0]  tot_abs;
    logic [20:0]         nmix;
    logic [39:0]         q_prod;
    logic                out_free;

    assign turn    = partial_turn(phase_reg[vidx_reg], kidx_reg);
    assign rfold   = turn[30] ? ~turn[29:0] : turn[29:0];
    assign rom_idx = rfold[29:20];

    assign sine_s   = mac_neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});
    assign mac_prod = partial_weight(mac_k_reg) * sine_s;

    // divide by 2^24 truncating toward zero
    assign prod_bias = prod_reg[57] ? prod_reg + 58'sd16777215 : prod_reg;
    assign vval      = prod_bias[57:24];
    assign dec_prod  = amp_reg[vidx_reg] * cfg.decay;

    assign pick_v   = (next_voice_reg >= VOICE_W'(VOICES)) ? '0 : next_voice_reg;
    assign pick_nxt = (pick_v == VOICE_W'(VOICES - 1)) ? '0 : pick_v + 1'b1;

    assign tot_abs  = total_reg[36] ? -total_reg : total_reg;
    assign nmix     = mag_reg[50:30];
    assign q_prod   = nmix[18:0] * RECIP9;
    assign out_free = ~out_vld_reg | m_tready;

    assign pop = (state_reg == ST_IDLE) & head.valid;

    always_ff @(posedge aclk) begin
        rom_q_reg   <= SINE_ROM[rom_idx];
        mac_k_reg   <= kidx_reg;
        mac_neg_reg <= turn[31];
        if (mac_vld_reg) sum_reg <= sum_reg + mac_prod;

        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_voice_reg <= '0;
            mac_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
            vidx_reg       <= '0;
            kidx_reg       <= '0;
            for (int i = 0; i < VOICES; i++) begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
                amp_reg[i]   <= PEAK_RESET;
            end
        end else begin
            mac_vld_reg <= (state_reg == ST_PART);
            // FIN3 reloads the output register itself
            if (out_vld_reg && m_tready && state_reg != ST_FIN3) out_vld_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (head.valid) begin
                        if (head.item.pick) begin
                            phase_reg[pick_v] <= '0;
                            step_reg[pick_v]  <= head.item.step;
                            amp_reg[pick_v]   <= cfg.peak;
                            next_voice_reg    <= pick_nxt;
                        end else begin
                            vidx_reg  <= '0;
                            kidx_reg  <= '0;
                            sum_reg   <= '0;
                            total_reg <= '0;
                            state_reg <= ST_PART;
                        end
                    end
                end
                ST_PART: begin
                    if (kidx_reg == PART_W'(PARTIALS - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        kidx_reg <= kidx_reg + 1'b1;
                    end
                end
                ST_DRAIN: state_reg <= ST_VMUL;
                ST_VMUL: begin
                    prod_reg  <= sum_reg * $signed({1'b0, amp_reg[vidx_reg]});
                    state_reg <= ST_VACC;
                end
                ST_VACC: begin
                    total_reg          <= total_reg + 37'(vval);
                    amp_reg[vidx_reg]  <= dec_prod[47:24];
                    phase_reg[vidx_reg] <= phase_reg[vidx_reg]
                                         + {4'd0, step_reg[vidx_reg]};
                    kidx_reg <= '0;
                    sum_reg  <= '0;
                    if (vidx_reg == VOICE_W'(VOICES - 1)) begin
                        state_reg <= ST_FIN1;
                    end else begin
                        vidx_reg  <= vidx_reg + 1'b1;
                        state_reg <= ST_PART;
                    end
                end
                ST_FIN1: begin
                    neg_reg   <= total_reg[36];
                    mag_reg   <= tot_abs[35:0] * 15'd32766;
                    state_reg <= ST_FIN2;
                end
                ST_FIN2: begin
                    sat_reg   <= (nmix >= SAT_LIM);
                    nq_reg    <= q_prod[38:24];
                    state_reg <= ST_FIN3;
                end
                ST_FIN3: begin
                    if (out_free) begin
                        out_vld_reg <= 1'b1;
                        if (sat_reg)      out_reg <= neg_reg ? 16'h8000 : 16'h7fff;
                        else if (neg_reg) out_reg <= -{1'b0, nq_reg};
                        else              out_reg <= {1'b0, nq_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

@@ rtl/decaying_additive_voice_bank.sv @@
// ----------------------------------------------------------------------------
// decaying_additive_voice_bank
// Nine-voice additive synthesizer with per-sample amplitude decay.
//
//   channel   dir  data                          user
//   s_        in   tdata[31:0] phase_step        tuser[0] operation (1 = pick)
//   m_        out  tdata[15:0] sample (signed)   -
//   apb       in   0x0 peak_amplitude, 0x4 decay_factor
//
// A pick is handled in the engine's idle state. A tick runs, for each voice,
// six partials through the single sine ROM read port, a MAC drain, an amplitude
// multiply and an accumulate, then dispatch and mixing produce the sample.
// Reset is synchronous; the engine is ready the cycle after reset drops.
// The two-entry input queue keeps accepting, while it has room, as the engine works; a held
// result stalls only the end of the next tick.
// ----------------------------------------------------------------------------
module decaying_additive_voice_bank (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] phase_step
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dav_pkg::*;

    dav_head_t head;
    dav_cfg_t  cfg;
    logic      pop;

    dav_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dav_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    dav_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/dav_checker.sv @@
// ----------------------------------------------------------------------------
// dav_checker
// Port-level checks on the voice bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dav_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_ALWAYS(a_no_out_after_reset, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_peak_readback, aclk, aresetn, psel && penable && pwrite && pready && paddr == 3'd0 |=> paddr != 3'd0 || prdata == {8'd0, $past(pwdata[23:0])})
    `ASSERT_CLK(a_rdata_upper_zero, aclk, aresetn, prdata[31:24] == 8'd0)

endmodule

bind decaying_additive_voice_bank dav_checker u_dav_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nine-voice decaying additive synthesizer.
// Picks and ticks are streamed in with random gaps and back-pressure. A local
// fixed-point model of the voice bank predicts each tick's sample, and every
// output beat is checked in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dav_pkg::*;

    localparam int LATENCY_WAIT = 120;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef struct {
        logic        op;
        logic [31:0] step;
    } note_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] phase_step
    logic [0:0]  s_tuser = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] sample
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    decaying_additive_voice_bank i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Local voice bank model
    logic [15:0]       sine_q15 [SINE_DEPTH];
    logic [PHASE_W-1:0] phase_acc [VOICES];
    logic [STEP_W-1:0]  voice_inc [VOICES];
    logic [AMP_W-1:0]   voice_amp [VOICES];
    int                 pick_slot;
    logic [AMP_W-1:0]   peak_cfg;
    logic [AMP_W-1:0]   decay_cfg;
    longint             partial_gain [PARTIALS] = '{32768, 2731, -19115, 1365, -17749, -11605};

    note_cmd_t   pending_cmds [$];
    logic [15:0] sample_q [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    function automatic void fill_sine_q15();
        longint unsigned x, x2, term, v;
        longint          s;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x = (longint'(i) * 64'd1686629713) / SINE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            s = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                s = (k & 1) ? s - longint'(term) : s + longint'(term);
            end
            if (s < 0) s = 0;
            if (s > (longint'(1) << 30)) s = longint'(1) << 30;
            v = (longint'(s) * 32767 + (longint'(1) << 29)) >> 30;
            sine_q15[i] = (v > 32767) ? 16'd32767 : v[15:0];
        end
    endfunction

    function automatic longint sine_lookup(logic [31:0] u);
        logic [29:0] r;
        longint      mag;
        r = u[30] ? ~u[29:0] : u[29:0];
        mag = longint'(sine_q15[r[29:20]]);
        return u[31] ? -mag : mag;
    endfunction

    function automatic logic [15:0] mix_tick_sample();
        logic [PHASE_W-1:0] p;
        logic [31:0]        turn [PARTIALS];
        logic [47:0]        prod;
        longint             sum, total, s;
        total = 0;
        for (int v = 0; v < VOICES; v++) begin
            p = phase_acc[v];
            turn[0] = p[31:0];
            turn[1] = {p[30:0], 1'b0};
            turn[2] = p[32:1];
            turn[3] = {p[28:0], 3'b000};
            turn[4] = p[33:2];
            turn[5] = p[35:4];
            sum = 0;
            for (int k = 0; k < PARTIALS; k++)
                sum += partial_gain[k] * sine_lookup(turn[k]);
            total += (sum * longint'({40'd0, voice_amp[v]})) / (longint'(1) << 24);
            prod = {24'd0, voice_amp[v]} * {24'd0, decay_cfg};
            voice_amp[v] = prod[47:24];
            phase_acc[v] = phase_acc[v] + {4'd0, voice_inc[v]};
        end
        s = (total * 32766) / (longint'(VOICES) << 30);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    function automatic void apply_note_cmd(logic op, logic [31:0] step);
        int v;
        if (op == OP_PICK) begin
            v = (pick_slot >= VOICES) ? 0 : pick_slot;
            phase_acc[v] = '0;
            voice_inc[v] = step;
            voice_amp[v] = peak_cfg;
            pick_slot = (v + 1 >= VOICES) ? 0 : v + 1;
        end else begin
            sample_q.push_back(mix_tick_sample());
        end
    endfunction

    // Driver
    always @(posedge aclk) begin
        note_cmd_t c;
        if (s_tvalid && s_tready)
            apply_note_cmd(s_tuser[0], s_tdata);
        if (!s_tvalid || s_tready) begin
            if (aresetn && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.op;
                s_tdata  <= c.step;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        logic [15:0] want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("** decaying_additive_voice_bank: FAILED **");
            $finish;
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        if (m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected sample beat, actual %0d", $time, $signed(m_tdata));
                fail_count++;
            end else begin
                want = sample_q.pop_front();
                if (want !== m_tdata) begin
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, $signed(want), $signed(m_tdata));
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_tvalid || sample_q.size() > 0)
            @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_PEAK) peak_cfg = data[AMP_W-1:0];
        else if (addr == ADDR_DECAY) decay_cfg = data[AMP_W-1:0];
    endtask

    task automatic push_cmd(logic op, logic [31:0] step);
        note_cmd_t c;
        c.op = op;
        c.step = step;
        pending_cmds.push_back(c);
    endtask

    task automatic push_random(int n);
        logic [31:0] st;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0:       st = $urandom_range(4000000);
                1:       st = $urandom_range(200000000);
                default: st = $urandom;
            endcase
            push_cmd(($urandom_range(99) < 35) ? OP_PICK : OP_TICK, st);
        end
    endtask

    initial begin
        logic [31:0] dir_steps [10] = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h1,
                                        32'h4000_0000, 32'h0100_0000, 32'h1234_5678,
                                        32'h7FFF_FFFF, 32'h0008_0000, 32'hC000_0000};
        fill_sine_q15();
        peak_cfg = PEAK_RESET;
        decay_cfg = DECAY_RESET;
        pick_slot = 0;
        for (int v = 0; v < VOICES; v++) begin
            phase_acc[v] = '0;
            voice_inc[v] = '0;
            voice_amp[v] = PEAK_RESET;
        end
        send_idle_pct = 34; recv_idle_pct = 49;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: silent bank, picks of extreme steps, round-robin wrap
        push_cmd(OP_TICK, 32'hFFFF_FFFF);
        push_cmd(OP_TICK, 32'h0);
        for (int i = 0; i < 10; i++) begin
            push_cmd(OP_PICK, dir_steps[i]);
            if (i % 2 == 1) push_cmd(OP_TICK, ~dir_steps[i]);
        end
        for (int i = 0; i < 6; i++) push_cmd(OP_TICK, 32'h0);
        wait_drained();

        // full peak, near-unity decay: mix may saturate
        apb_write(ADDR_PEAK, 32'hFFFF_FFFF);
        apb_write(ADDR_DECAY, 32'h00FF_FFFF);
        for (int i = 0; i < 9; i++) push_cmd(OP_PICK, 32'h0);
        push_random(120);
        wait_drained();

        apb_write(ADDR_PEAK, $urandom_range(24'hFFFFFF));
        apb_write(ADDR_DECAY, 32'h0);
        push_random(40);
        wait_drained();

        apb_write(ADDR_PEAK, 32'h0);
        apb_write(ADDR_DECAY, 24'hFF0000 + $urandom_range(16'hFFFF));
        send_idle_pct = 49; recv_idle_pct = 34;
        push_random(50);
        wait_drained();

        apb_write(ADDR_PEAK, 24'hC00000 + $urandom_range(22'h3FFFFF));
        apb_write(ADDR_DECAY, DECAY_RESET);
        push_random(100);
        wait_drained();

        apb_write(ADDR_PEAK, $urandom_range(24'hFFFFFF));
        apb_write(ADDR_DECAY, 24'hFFF000 + $urandom_range(12'hFFF));
        send_idle_pct = 0; recv_idle_pct = 0;
        push_random(80);
        // hold off until every sample is back, then continue
        while (pending_cmds.size() > 0 || s_tvalid || sample_q.size() > 0)
            @(posedge aclk);
        push_random(80);
        wait_drained();

        if (fail_count == 0)
            $display("** decaying_additive_voice_bank: PASSED **");
        else
            $display("** decaying_additive_voice_bank: FAILED **");
        $finish;
    end

endmodule
